FILE: hdl/mlp_pkg.sv
// shared types and constants of the one-hidden-layer perceptron block
// holds the field widths, register codes, state encoding and the tanh table builder
// no dependencies
package mlp_pkg;

	// stream payload widths
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 24;

	// field widths
	localparam int WADDR_W  = 11;
	localparam int VALUE_W  = 16;
	localparam int OIDX_W   = 3;
	localparam int CNT_W    = 6;
	localparam int OCNT_W   = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 6;

	// computed weight addresses stay below 63*63 + 63 + 63*15 + 15
	localparam int CADDR_W = 13;

	// accumulator holds up to 64 products of 16x16 bits
	localparam int ACC_W  = 40;
	localparam int PROD_W = 32;

	// tanh table: magnitude index 0..512, entries 0..4096
	localparam int TANH_N   = 513;
	localparam int TANH_W   = 13;
	localparam int TANH_IDX_W = 10;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 2'd2;

	// item kinds carried in tuser
	localparam logic CMD_WEIGHT = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_HID   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	typedef logic [TANH_W-1:0] tanh_tbl_t [TANH_N];

	// round(4096*tanh(k/64)) for k = 0..512, built at elaboration
	function automatic tanh_tbl_t build_tanh_table();
		tanh_tbl_t tbl;
		real x;
		int q;
		for (int k = 0; k < TANH_N; k++) begin
			x = k * 0.015625;
			q = $rtoi($tanh(x) * 8192.0);
			tbl[k] = TANH_W'((q + 1) >>> 1);
		end
		return tbl;
	endfunction

	// floor divide by 4096, then saturate to 16 bits signed
	function automatic logic signed [VALUE_W-1:0] scale_sat(logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] s;
		s = v >>> 12;
		if (s > ACC_W'(32767))
			return 16'sh7FFF;
		else if (s < -ACC_W'(32768))
			return 16'sh8000;
		else
			return s[VALUE_W-1:0];
	endfunction

endpackage

FILE: hdl/mlp_tanh_rom.sv
// tanh lookup rom with registered read, indexed by magnitude of the bucket
// depends on mlp_pkg for the table builder and widths
module mlp_tanh_rom (
	input  logic                              clk,
	input  logic [mlp_pkg::TANH_IDX_W-1:0]    mag,
	output logic [mlp_pkg::TANH_W-1:0]        data
);
	import mlp_pkg::*;

	localparam tanh_tbl_t TANH_TBL = build_tanh_table();

	// registered read; indexes above 512 never occur
	always_ff @(posedge clk) begin
		if (32'(mag) < TANH_N)
			data <= TANH_TBL[mag];
		else
			data <= TANH_TBL[TANH_N-1];
	end

endmodule

FILE: hdl/mlp_one_hidden_layer_inference.sv
// top level of the one-hidden-layer perceptron forward pass in signed Q4.12
// depends on mlp_pkg and mlp_tanh_rom
// weight store, input buffer and hidden values are synchronous memories
//
// Weight items (tuser 0) are accepted one per cycle and write the weight store. Sample items
// (tuser 1) are accepted one per cycle, except the one that completes a vector: it starts the
// forward pass and no item is accepted until the last output neuron has been issued.
// One multiply-accumulate unit reads one weight per cycle from the single read port of
// the weight store, except while an output neuron waits to start. A vector runs the hidden
// layer (H neurons of I+1 terms each), drains the hidden results, and then runs each output
// neuron over H+1 terms (I and H are the programmed counts). Each output neuron
// starts only when the result register is free. No clearing pass is needed after reset.
module mlp_one_hidden_layer_inference #(
	parameter int MAX_INPUTS   = 32,
	parameter int MAX_HIDDEN   = 32,
	parameter int MAX_OUTPUTS  = 8,
	parameter int WEIGHT_DEPTH = 2048
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// slave stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// weight_addr[10:0], weight_value[26:11], sample_value[42:27], zero pad
	input  logic [mlp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// cmd
	input  logic                                s_axis_tuser,
	// master stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// out_index[2:0], out_value[18:3], zero pad
	output logic [mlp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tlast,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [mlp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mlp_pkg::CFG_DAT_W-1:0]       cfg_data
);
	import mlp_pkg::*;

	localparam int WAW = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
	localparam int IAW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int HAW = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
	localparam int DRAIN_LEN = 5;
	localparam int DRN_W = $clog2(DRAIN_LEN);

	// memories
	logic signed [VALUE_W-1:0] wmem [WEIGHT_DEPTH];
	logic signed [VALUE_W-1:0] ibuf [MAX_INPUTS];
	logic signed [VALUE_W-1:0] hmem [MAX_HIDDEN];

	// configuration and sequencer state
	logic [CNT_W-1:0]   ni_q, nh_q;
	logic [OCNT_W-1:0]  no_q;
	logic [CNT_W-1:0]   pos_q;
	state_t             state_q;
	logic [CNT_W-1:0]   term_q, neur_q;
	logic [CADDR_W-1:0] waddr_q, baddr_q, p2_q;
	logic [DRN_W-1:0]   drain_q;
	logic               busy_q;

	// pipeline
	logic                      v_s1, first_s1, oph_s1, olast_s1, wok_s1;
	logic [CNT_W-1:0]          nidx_s1;
	logic signed [VALUE_W-1:0] w_rd_s1, in_rd_s1, hv_rd_s1;
	logic                      v_s2, first_s2, last_s2, oph_s2, olast_s2, last_s1;
	logic [CNT_W-1:0]          nidx_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      done_s3, oph_s3, olast_s3;
	logic [CNT_W-1:0]          nidx_s3;
	logic                      hv_s4, neg_s4;
	logic [CNT_W-1:0]          nidx_s4;
	logic [TANH_W-1:0]         rom_q;

	// result register
	logic                      out_valid_q, out_last_q;
	logic [OIDX_W-1:0]         out_idx_q;
	logic signed [VALUE_W-1:0] out_val_q;

	// input field unpacking
	logic [WADDR_W-1:0]        in_waddr;
	logic signed [VALUE_W-1:0] in_wval, in_sample;
	logic                      in_acc, out_take;
	logic [31:0]               wr_ext, pos_ext;

	assign in_waddr  = s_axis_tdata[10:0];
	assign in_wval   = s_axis_tdata[26:11];
	assign in_sample = s_axis_tdata[42:27];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_take = out_valid_q && m_axis_tready;
	assign wr_ext   = 32'(in_waddr);
	assign pos_ext  = 32'(pos_q);

	// issue stage decode
	logic               issue_v, is_first, is_last, start_ok, in_out, neur_end;
	logic [CNT_W-1:0]   term_lim, neur_lim;
	logic [CADDR_W-1:0] raddr;
	logic [31:0]        raddr_ext, rd_pos;

	assign in_out    = (state_q == ST_OUT);
	assign start_ok  = !busy_q && (!out_valid_q || m_axis_tready);
	assign is_first  = (term_q == '0);
	assign issue_v   = (state_q == ST_HID) || (in_out && (!is_first || start_ok));
	assign term_lim  = in_out ? nh_q : ni_q;
	assign neur_lim  = in_out ? CNT_W'(no_q) : nh_q;
	assign is_last   = (term_q == term_lim);
	assign neur_end  = (neur_q == neur_lim - CNT_W'(1));
	assign raddr     = is_first ? baddr_q : waddr_q;
	assign raddr_ext = 32'(raddr);
	assign rd_pos    = 32'(term_q) - 32'd1;

	// weight store: write on weight items, read one word per issue cycle
	always_ff @(posedge clk) begin
		if (in_acc && s_axis_tuser == CMD_WEIGHT && wr_ext < WEIGHT_DEPTH)
			wmem[wr_ext[WAW-1:0]] <= in_wval;
		w_rd_s1 <= wmem[raddr_ext[WAW-1:0]];
	end

	// input buffer
	always_ff @(posedge clk) begin
		if (in_acc && s_axis_tuser == CMD_SAMPLE && pos_ext < MAX_INPUTS)
			ibuf[pos_ext[IAW-1:0]] <= in_sample;
		in_rd_s1 <= ibuf[rd_pos[IAW-1:0]];
	end

	// hidden values, written back after the tanh lookup
	logic signed [VALUE_W-1:0] hv_val;
	logic [31:0]               hw_ext;
	assign hv_val = neg_s4 ? -VALUE_W'(rom_q) : VALUE_W'(rom_q);
	assign hw_ext = 32'(nidx_s4);

	always_ff @(posedge clk) begin
		if (hv_s4)
			hmem[hw_ext[HAW-1:0]] <= hv_val;
		hv_rd_s1 <= hmem[rd_pos[HAW-1:0]];
	end

	// configuration registers and input position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ni_q  <= CNT_W'(8);
			nh_q  <= CNT_W'(16);
			no_q  <= OCNT_W'(4);
			pos_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INPUT_COUNT: begin
					ni_q  <= (cfg_data == '0) ? CNT_W'(1) :
						(32'(cfg_data) > MAX_INPUTS) ? CNT_W'(MAX_INPUTS) : cfg_data;
					pos_q <= '0;
				end
				CFG_HIDDEN_COUNT: begin
					nh_q  <= (cfg_data == '0) ? CNT_W'(1) :
						(32'(cfg_data) > MAX_HIDDEN) ? CNT_W'(MAX_HIDDEN) : cfg_data;
					pos_q <= '0;
				end
				CFG_OUTPUT_COUNT: begin
					no_q  <= (cfg_data[OCNT_W-1:0] == '0) ? OCNT_W'(1) :
						(32'(cfg_data[OCNT_W-1:0]) > MAX_OUTPUTS) ? OCNT_W'(MAX_OUTPUTS) :
						cfg_data[OCNT_W-1:0];
					pos_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (in_acc && s_axis_tuser == CMD_SAMPLE) begin
			if (7'(pos_q) + 7'd1 < 7'(ni_q))
				pos_q <= pos_q + CNT_W'(1);
			else
				pos_q <= '0;
		end
	end

	// sequencer: hidden terms, drain, then output terms
	logic vec_done;
	assign vec_done = in_acc && s_axis_tuser == CMD_SAMPLE && !(7'(pos_q) + 7'd1 < 7'(ni_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			term_q  <= '0;
			neur_q  <= '0;
			waddr_q <= '0;
			baddr_q <= '0;
			p2_q    <= '0;
			drain_q <= '0;
			busy_q  <= 1'b0;
		end else begin
			if (done_s3 && oph_s3)
				busy_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (vec_done) begin
						state_q <= ST_HID;
						term_q  <= '0;
						neur_q  <= '0;
						waddr_q <= '0;
						baddr_q <= CADDR_W'(ni_q) * CADDR_W'(nh_q);
						p2_q    <= CADDR_W'(nh_q) * CADDR_W'(no_q);
					end
				end
				ST_DRAIN: begin
					if (drain_q == DRN_W'(DRAIN_LEN - 1)) begin
						state_q <= ST_OUT;
						term_q  <= '0;
						neur_q  <= '0;
						waddr_q <= baddr_q;
						baddr_q <= baddr_q + p2_q;
					end
					drain_q <= drain_q + DRN_W'(1);
				end
				ST_HID, ST_OUT: begin
					if (issue_v) begin
						if (in_out && is_first)
							busy_q <= 1'b1;
						if (!is_first)
							waddr_q <= waddr_q + CADDR_W'(1);
						if (is_last) begin
							term_q  <= '0;
							baddr_q <= baddr_q + CADDR_W'(1);
							neur_q  <= neur_q + CNT_W'(1);
							if (neur_end) begin
								state_q <= in_out ? ST_IDLE : ST_DRAIN;
								drain_q <= '0;
							end
						end else begin
							term_q <= term_q + CNT_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// pipeline control tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done_s3 <= 1'b0;
			hv_s4   <= 1'b0;
		end else begin
			v_s1    <= issue_v;
			v_s2    <= v_s1;
			done_s3 <= v_s2 && last_s2;
			hv_s4   <= done_s3 && !oph_s3;
		end
	end

	// pipeline payload
	logic signed [VALUE_W-1:0] act_s1, wgt_s1, sat_s3;
	logic signed [TANH_IDX_W-1:0] bkt_s3;
	logic [TANH_IDX_W-1:0]        mag_s3;

	assign act_s1 = first_s1 ? 16'sd4096 : (oph_s1 ? hv_rd_s1 : in_rd_s1);
	assign wgt_s1 = wok_s1 ? w_rd_s1 : '0;
	assign sat_s3 = scale_sat(acc_q);
	assign bkt_s3 = sat_s3[VALUE_W-1:VALUE_W-TANH_IDX_W];
	assign mag_s3 = bkt_s3[TANH_IDX_W-1] ? TANH_IDX_W'(-bkt_s3) : TANH_IDX_W'(bkt_s3);

	always_ff @(posedge clk) begin
		// stage 1: addresses out of the store read as zero
		first_s1 <= is_first;
		last_s1  <= is_last;
		oph_s1   <= in_out;
		olast_s1 <= (neur_q == CNT_W'(no_q) - CNT_W'(1));
		nidx_s1  <= neur_q;
		wok_s1   <= (raddr_ext < WEIGHT_DEPTH);
		// stage 2: product
		prod_s2  <= PROD_W'(act_s1) * PROD_W'(wgt_s1);
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		oph_s2   <= oph_s1;
		olast_s2 <= olast_s1;
		nidx_s2  <= nidx_s1;
		// accumulate, bias term opens a neuron
		if (v_s2)
			acc_q <= first_s2 ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		oph_s3   <= oph_s2;
		olast_s3 <= olast_s2;
		nidx_s3  <= nidx_s2;
		// stage 4: tanh sign and neuron
		neg_s4   <= bkt_s3[TANH_IDX_W-1];
		nidx_s4  <= nidx_s3;
	end

	mlp_tanh_rom u_tanh (
		.clk  (clk),
		.mag  (mag_s3),
		.data (rom_q)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (done_s3 && oph_s3)
			out_valid_q <= 1'b1;
		else if (out_take)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done_s3 && oph_s3) begin
			out_idx_q  <= nidx_s3[OIDX_W-1:0];
			out_val_q  <= sat_s3;
			out_last_q <= olast_s3;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - OIDX_W - VALUE_W)'(0), out_val_q, out_idx_q};

	// a finished output never lands on an untaken result
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(done_s3 && oph_s3) |-> (!out_valid_q || m_axis_tready))
		else $error("output result overwrote a pending transaction");

	// only one output neuron in flight
	a_single_output: assert property (@(posedge clk) disable iff (!arst_n)
		(in_out && issue_v && is_first) |-> !busy_q)
		else $error("output neuron issued while another is in flight");

	// hidden write-back is finished before the output layer reads
	a_hidden_drained: assert property (@(posedge clk) disable iff (!arst_n)
		in_out |-> (!hv_s4 && !(done_s3 && !oph_s3)))
		else $error("hidden value still pending during output layer");

	// input position stays inside the vector
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (pos_q < ni_q))
		else $error("input position past input count");

endmodule

FILE: verif/mlp_one_hidden_layer_inference_tb.sv
`timescale 1ns / 100ps
// testbench for the one-hidden-layer perceptron block: weight loads, sample vectors, counts
// a scoreboard class predicts every output neuron and checks the output stream against it
// depends on mlp_pkg and mlp_one_hidden_layer_inference
module mlp_one_hidden_layer_inference_tb;
	import mlp_pkg::*;

	localparam int IN_MAX       = 32;
	localparam int HID_MAX      = 32;
	localparam int OUT_MAX      = 8;
	localparam int STORE_DEPTH  = 2048;
	localparam int SETTLE       = 16;
	localparam int LIMIT        = 1000000;
	localparam int RANDOM_ITEMS = 80;

	// register index past the end of the list, the block ignores it
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		logic [OIDX_W-1:0]         index;
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} neuron_out_t;

	class mlp_scoreboard;
		logic signed [VALUE_W-1:0] weights [STORE_DEPTH];
		logic signed [VALUE_W-1:0] samples [IN_MAX];
		int                        hidden [HID_MAX];
		int                        tanh_mag [513];
		int unsigned               position;
		int unsigned               n_in;
		int unsigned               n_hid;
		int unsigned               n_out;
		neuron_out_t               pending [$];
		int                        fails;

		function new();
			real e;
			// round(4096*tanh(k/64)) for the magnitude of each bucket
			for (int k = 0; k <= 512; k++) begin
				e = $exp(-2.0 * k / 64.0);
				tanh_mag[k] = $rtoi($floor(4096.0 * (1.0 - e) / (1.0 + e) + 0.5));
			end
			n_in = 8;
			n_hid = 16;
			n_out = 4;
			position = 0;
			fails = 0;
		endfunction

		function int unsigned clamp_count(int unsigned v, int unsigned hi);
			return (v < 1) ? 1 : ((v > hi) ? hi : v);
		endfunction

		// count write: saturate into range, restart the vector
		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				CFG_INPUT_COUNT: n_in = clamp_count(data, IN_MAX);
				CFG_HIDDEN_COUNT: n_hid = clamp_count(data, HID_MAX);
				CFG_OUTPUT_COUNT: n_out = clamp_count(data[OCNT_W-1:0], OUT_MAX);
				default: return;
			endcase
			position = 0;
		endfunction

		// floor by 4096, then saturate to 16 bits
		function logic signed [VALUE_W-1:0] requantize(longint acc);
			longint s;
			s = acc >>> 12;
			if (s > 32767)
				return 16'sh7FFF;
			if (s < -32768)
				return 16'sh8000;
			return s[VALUE_W-1:0];
		endfunction

		// accepted input transaction: weight load or sample, forward pass on the last sample
		function void note_input(logic cmd, logic [WADDR_W-1:0] addr,
				logic signed [VALUE_W-1:0] wval, logic signed [VALUE_W-1:0] sval);
			longint      acc;
			int          s;
			int unsigned base;
			neuron_out_t r;
			if (cmd == CMD_WEIGHT) begin
				weights[addr] = wval;
				return;
			end
			samples[position] = sval;
			if (position + 1 < n_in) begin
				position++;
				return;
			end
			position = 0;
			// hidden layer through the tanh buckets
			for (int h = 0; h < n_hid; h++) begin
				acc = longint'(weights[n_in * n_hid + h]) * 4096;
				for (int i = 0; i < n_in; i++)
					acc += longint'(samples[i]) * longint'(weights[h * n_in + i]);
				s = int'(requantize(acc)) >>> 6;
				hidden[h] = (s >= 0) ? tanh_mag[s] : -tanh_mag[-s];
			end
			// output layer, no activation
			base = n_in * n_hid + n_hid;
			for (int o = 0; o < n_out; o++) begin
				acc = longint'(weights[base + n_hid * n_out + o]) * 4096;
				for (int h = 0; h < n_hid; h++)
					acc += longint'(hidden[h]) * longint'(weights[base + o * n_hid + h]);
				r.index = o[OIDX_W-1:0];
				r.value = requantize(acc);
				r.last = (o + 1 == n_out);
				pending.push_back(r);
			end
		endfunction

		// accepted output transaction against the oldest prediction
		function void check_result(logic [OIDX_W-1:0] idx, logic signed [VALUE_W-1:0] val,
				logic last);
			neuron_out_t want;
			if (pending.size() == 0) begin
				$error("out_value: expected no result, got %0d (out_index %0d)", val, idx);
				fails++;
				return;
			end
			want = pending.pop_front();
			if (idx !== want.index) begin
				$error("out_index: expected %0d, got %0d", want.index, idx);
				fails++;
			end
			if (val !== want.value) begin
				$error("out_value: expected %0d, got %0d", want.value, val);
				fails++;
			end
			if (last !== want.last) begin
				$error("out_last: expected %0d, got %0d", want.last, last);
				fails++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DAT_W-1:0]   cfg_data = '0;

	mlp_scoreboard sb = new();
	bit            loaded [STORE_DEPTH];
	bit            steady = 1'b0;
	int unsigned   sent_items = 0;
	int unsigned   cycles = 0;

	mlp_one_hidden_layer_inference dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// output side: check each transaction, stall at random
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata[OIDX_W-1:0], m_axis_tdata[OIDX_W +: VALUE_W],
				m_axis_tlast);
		m_axis_tready <= steady || ($urandom_range(99) >= 9);
	end

	// mostly values within plus or minus one, some over the whole range
	function automatic logic [VALUE_W-1:0] rand_value();
		case ($urandom_range(3))
			0: return VALUE_W'($urandom);
			1: return VALUE_W'(int'($urandom_range(1024)) - 512);
			default: return VALUE_W'(int'($urandom_range(8192)) - 4096);
		endcase
	endfunction

	// one input transaction, with random idle cycles ahead of it
	task automatic send_item(input logic cmd, input logic [WADDR_W-1:0] addr,
			input logic [VALUE_W-1:0] wval, input logic [VALUE_W-1:0] sval);
		while (!steady && $urandom_range(99) < 9) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {{(IN_TDATA_W - WADDR_W - 2 * VALUE_W){1'b0}}, sval, wval, addr};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_input(cmd, addr, wval, sval);
		sent_items++;
	endtask

	task automatic send_weight(input logic [WADDR_W-1:0] addr, input logic [VALUE_W-1:0] val);
		loaded[addr] = 1'b1;
		send_item(CMD_WEIGHT, addr, val, VALUE_W'($urandom));
	endtask

	task automatic send_sample(input logic [VALUE_W-1:0] val);
		send_item(CMD_SAMPLE, WADDR_W'($urandom), VALUE_W'($urandom), val);
	endtask

	// samples, with a stray weight load now and then
	task automatic send_vector(input int unsigned count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) == 0)
				send_weight(WADDR_W'($urandom), rand_value());
			send_sample(rand_value());
		end
	endtask

	// load every weight the current counts read that was never loaded, rewrite a few others
	task automatic fill_layout(input int unsigned rewrite_pct);
		int unsigned span;
		span = sb.n_in * sb.n_hid + sb.n_hid + sb.n_out * sb.n_hid + sb.n_out;
		for (int a = 0; a < span; a++)
			if (!loaded[a] || $urandom_range(99) < rewrite_pct)
				send_weight(WADDR_W'(a), rand_value());
	endtask

	// hold the sender until every predicted output has come out
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_register(idx, data);
	endtask

	task automatic configure(input logic [CFG_DAT_W-1:0] raw_in, input logic [CFG_DAT_W-1:0] raw_hid,
			input logic [CFG_DAT_W-1:0] raw_out, input bit poke_unused);
		wait_idle();
		write_reg(CFG_INPUT_COUNT, raw_in);
		write_reg(CFG_HIDDEN_COUNT, raw_hid);
		write_reg(CFG_OUTPUT_COUNT, raw_out);
		if (poke_unused)
			write_reg(CFG_UNUSED, CFG_DAT_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned rand_start;
		int unsigned n;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// counts out of reset, extreme samples first
		fill_layout(0);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_vector(4);

		// counts written as zero saturate to one neuron per layer
		configure(6'd0, 6'd0, 6'd0, 1'b0);
		send_weight(11'd0, 16'h7FFF);
		send_weight(11'd1, 16'h7FFF);
		send_weight(11'd2, 16'h7FFF);
		send_weight(11'd3, 16'h7FFF);
		// both layers saturate high
		send_sample(16'h7FFF);
		// hidden saturates low, output cancels against its bias
		send_sample(16'h8000);
		send_weight(11'd3, 16'h8000);
		// output saturates low
		send_sample(16'h8000);
		// hidden value from the bias alone
		send_sample(16'h0000);

		// output count 63 keeps its low nibble and saturates to the maximum
		configure(6'd3, 6'd2, 6'd63, 1'b0);
		fill_layout(30);
		send_sample(rand_value());
		// a write to the unused index leaves the partial vector in place
		wait_idle();
		write_reg(CFG_UNUSED, 6'd1);
		cfg_we <= 1'b0;
		send_sample(rand_value());
		send_sample(rand_value());
		// a count write drops the partial vector
		send_sample(rand_value());
		send_sample(rand_value());
		wait_idle();
		write_reg(CFG_INPUT_COUNT, 6'd3);
		cfg_we <= 1'b0;
		send_vector(3);

		// full input buffer and all output neurons, input count above the maximum
		configure(6'd40, 6'd1, 6'd8, 1'b1);
		fill_layout(0);
		send_weight(11'h7FF, 16'h8000);
		send_vector(IN_MAX);

		// random phases: mostly small networks, now and then any input and output count
		rand_start = sent_items;
		while (sent_items - rand_start < RANDOM_ITEMS) begin
			// one stretch of phases with both sides always ready
			steady = (sent_items - rand_start >= 20) && (sent_items - rand_start < 60);
			if ($urandom_range(9) == 0)
				configure(CFG_DAT_W'($urandom), CFG_DAT_W'($urandom_range(2, 1)),
					CFG_DAT_W'($urandom), $urandom_range(3) == 0);
			else
				configure(CFG_DAT_W'($urandom_range(6, 1)), CFG_DAT_W'($urandom_range(6, 1)),
					CFG_DAT_W'($urandom_range(9, 1)), $urandom_range(4) == 0);
			fill_layout((sb.n_in * sb.n_hid > 64) ? 1 : 15);
			n = $urandom_range(4, 1);
			repeat (n) send_vector(sb.n_in);
			// a vector cut short, dropped by the next count write
			if ($urandom_range(5) == 0)
				send_vector($urandom_range(sb.n_in - 1));
		end
		steady = 1'b0;

		wait_idle();
		if (sb.fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: sim.f
hdl/mlp_pkg.sv
hdl/mlp_tanh_rom.sv
hdl/mlp_one_hidden_layer_inference.sv
verif/mlp_one_hidden_layer_inference_tb.sv
